>>> hdl/bfa_pkg.sv
// Package for the bitmap frame allocator: transaction types, codes, sizes
// and the lowest-free-bit helper. No dependencies.
package bfa_pkg;

  localparam int unsigned BitmapWords = 128;
  localparam int unsigned WordBits    = 32;
  localparam int unsigned WordAddrW   = $clog2(BitmapWords);
  localparam int unsigned BitIdxW     = $clog2(WordBits);
  localparam logic [WordBits-1:0] FullWord = '1;

  // Operation codes
  localparam logic [1:0] KindAlloc = 2'd0;
  localparam logic [1:0] KindFree  = 2'd1;
  localparam logic [1:0] KindTest  = 2'd2;

  // Status codes
  localparam logic [1:0] StatDone     = 2'd0;
  localparam logic [1:0] StatNoChange = 2'd1;
  localparam logic [1:0] StatNoFrame  = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] frame_index;
    logic        kernel_page;
    logic        writable;
  } req_t;

  typedef struct packed {
    logic [11:0] result_frame;
    logic [1:0]  status;
    logic        frame_used;
    logic        entry_present;
    logic        entry_writable;
    logic        entry_user;
  } rsp_t;

  // Bitmap write port
  typedef struct packed {
    logic                 en;
    logic [WordAddrW-1:0] addr;
    logic [WordBits-1:0]  data;
  } mem_wr_t;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StFree,
    StTest
  } state_e;

  // Index of the lowest clear bit; isolate it with one add, then encode.
  function automatic logic [BitIdxW-1:0] first_zero(input logic [WordBits-1:0] word);
    logic [WordBits-1:0] inv;
    logic [WordBits-1:0] onehot;
    logic [BitIdxW-1:0]  idx;
    inv    = ~word;
    onehot = inv & (~inv + WordBits'(1));
    idx    = '0;
    for (int i = 0; i < WordBits; i++) begin
      if (onehot[i]) begin
        idx = idx | BitIdxW'(i);
      end
    end
    return idx;
  endfunction

endpackage

>>> hdl/bfa_bitmap_mem.sv
// Used/free bitmap storage: one write port, one registered read port.
// Per-word valid flops make unwritten words read as all free. Uses bfa_pkg.
module bfa_bitmap_mem (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             rd_en_i,
  input  logic [bfa_pkg::WordAddrW-1:0]    rd_addr_i,
  input  bfa_pkg::mem_wr_t                 wr_i,
  output logic [bfa_pkg::WordBits-1:0]     rd_data_o
);

  logic [bfa_pkg::WordBits-1:0]    mem_q [bfa_pkg::BitmapWords];
  logic [bfa_pkg::BitmapWords-1:0] valid_q;
  logic [bfa_pkg::WordBits-1:0]    rd_word_q;
  logic                            rd_valid_q;

  // Write and read the storage array
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_word_q <= mem_q[rd_addr_i];
    end
  end

  // Track which words hold written data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        valid_q[wr_i.addr] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  // Unwritten words read as all free
  assign rd_data_o = rd_valid_q ? rd_word_q : '0;

endmodule

>>> hdl/bitmap_frame_allocator.sv
// Bitmap frame allocator top level: request sequencer, first-fit scan and
// response register. Uses bfa_pkg and bfa_bitmap_mem.
//
//   channel   signals                        direction  handshake
//   request   start, busy, req_i             in         start && !busy
//   response  rsp_valid_o, rsp_o             out        one-cycle strobe
//   config    cfg_we_i, cfg_wdata_i          in         cfg_we_i
//
// Allocate with frame 0 scans one bitmap word per cycle through the memory
// read port, over at most min(words_q, 128) words (none when that is zero);
// no clear bit in that range gives no-frame status. Free of a nonzero frame and
// test read the word first; the other requests answer in the next cycle.
// Reset marks every frame free at once (per-word valid flops), no clearing
// pass. The receiver cannot stall.
module bitmap_frame_allocator (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  bfa_pkg::req_t   req_i,
  output logic            rsp_valid_o,
  output bfa_pkg::rsp_t   rsp_o,
  input  logic            cfg_we_i,
  input  logic [7:0]      cfg_wdata_i
);

  localparam int unsigned AW = bfa_pkg::WordAddrW;
  localparam int unsigned BW = bfa_pkg::BitIdxW;

  bfa_pkg::state_e  state_q, state_d;
  bfa_pkg::req_t    req_q, req_d;
  logic [AW-1:0]    scan_q, scan_d;
  logic [7:0]       words_q;
  logic [7:0]       limit;
  bfa_pkg::rsp_t    rsp_q, rsp_d;
  logic             rsp_valid_q, rsp_valid_d;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  bfa_pkg::mem_wr_t wr;
  logic [bfa_pkg::WordBits-1:0] word;
  logic [BW-1:0]    free_bit;
  logic [BW-1:0]    req_bit;
  logic             accept;

  bfa_bitmap_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .wr_i      (wr),
    .rd_data_o (word)
  );

  assign accept   = start && !busy;
  assign busy     = (state_q != bfa_pkg::StIdle);
  assign free_bit = bfa_pkg::first_zero(word);
  assign req_bit  = req_q.frame_index[BW-1:0];

  // Clamp the searchable word count to storage
  assign limit = (words_q > 8'(bfa_pkg::BitmapWords)) ? 8'(bfa_pkg::BitmapWords) : words_q;

  // Hold the configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      words_q <= 8'(bfa_pkg::BitmapWords);
    end else if (cfg_we_i) begin
      words_q <= cfg_wdata_i;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bfa_pkg::StIdle;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    scan_q <= scan_d;
    rsp_q  <= rsp_d;
  end

  // Sequencer: dispatch, scan, read-modify-write
  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    scan_d      = scan_q;
    rsp_d       = rsp_q;
    rsp_valid_d = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = scan_q;
    wr          = '0;

    case (state_q)
      bfa_pkg::StIdle: begin
        if (accept) begin
          req_d = req_i;
          rsp_d = '0;
          rsp_d.status = bfa_pkg::StatNoChange;
          case (req_i.kind)
            bfa_pkg::KindAlloc: begin
              if (req_i.frame_index != '0) begin
                rsp_d.result_frame = req_i.frame_index;
                rsp_valid_d        = 1'b1;
              end else if (limit == '0) begin
                rsp_d.status = bfa_pkg::StatNoFrame;
                rsp_valid_d  = 1'b1;
              end else begin
                scan_d  = '0;
                rd_en   = 1'b1;
                rd_addr = '0;
                state_d = bfa_pkg::StScan;
              end
            end
            bfa_pkg::KindFree: begin
              if (req_i.frame_index != '0) begin
                rd_en   = 1'b1;
                rd_addr = req_i.frame_index[11:BW];
                state_d = bfa_pkg::StFree;
              end else begin
                rsp_valid_d = 1'b1;
              end
            end
            bfa_pkg::KindTest: begin
              rd_en   = 1'b1;
              rd_addr = req_i.frame_index[11:BW];
              state_d = bfa_pkg::StTest;
            end
            default: begin
              rsp_valid_d = 1'b1;
            end
          endcase
        end
      end

      // One word per cycle; grant the lowest clear bit of the first non-full word
      bfa_pkg::StScan: begin
        if (word != bfa_pkg::FullWord) begin
          wr.en                = 1'b1;
          wr.addr              = scan_q;
          wr.data              = word | (bfa_pkg::WordBits'(1) << free_bit);
          rsp_d.result_frame   = {scan_q, free_bit};
          rsp_d.status         = bfa_pkg::StatDone;
          rsp_d.entry_present  = 1'b1;
          rsp_d.entry_writable = req_q.writable;
          rsp_d.entry_user     = ~req_q.kernel_page;
          rsp_valid_d          = 1'b1;
          state_d              = bfa_pkg::StIdle;
        end else if ((8'(scan_q) + 8'd1) >= limit) begin
          rsp_d.status = bfa_pkg::StatNoFrame;
          rsp_valid_d  = 1'b1;
          state_d      = bfa_pkg::StIdle;
        end else begin
          scan_d  = scan_q + AW'(1);
          rd_en   = 1'b1;
          rd_addr = scan_q + AW'(1);
        end
      end

      // Drop the frame's bit
      bfa_pkg::StFree: begin
        wr.en        = 1'b1;
        wr.addr      = req_q.frame_index[11:BW];
        wr.data      = word & ~(bfa_pkg::WordBits'(1) << req_bit);
        rsp_d.status = bfa_pkg::StatDone;
        rsp_valid_d  = 1'b1;
        state_d      = bfa_pkg::StIdle;
      end

      // Report the frame's bit
      bfa_pkg::StTest: begin
        rsp_d.result_frame = req_q.frame_index;
        rsp_d.status       = bfa_pkg::StatDone;
        rsp_d.frame_used   = word[req_bit];
        rsp_valid_d        = 1'b1;
        state_d            = bfa_pkg::StIdle;
      end

      default: begin
        state_d = bfa_pkg::StIdle;
      end
    endcase
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // A test transaction always goes through a memory read
  a_test_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.kind == bfa_pkg::KindTest) |=> busy)
    else $error("test request did not enter read state");

  // The response strobe comes only once the sequencer is back in idle
  a_rsp_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> !busy)
    else $error("response strobed while busy");

  // A grant carries done status; out-of-frames carries no frame
  a_grant_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_o.entry_present) |-> (rsp_o.status == bfa_pkg::StatDone))
    else $error("entry present without done status");

  a_noframe_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_o.status == bfa_pkg::StatNoFrame) |->
      (rsp_o.result_frame == '0 && !rsp_o.entry_present))
    else $error("out-of-frames response carries a frame");

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for bitmap_frame_allocator: request driver, response
// checker and a first-fit bitmap predictor. Depends on bfa_pkg and the RTL.
`timescale 1ns / 100ps

module tb_top;

  localparam int          ClkHalfNs   = 6;
  localparam int          ClkPeriodNs = 2 * ClkHalfNs;
  localparam int          RandPhases  = 11;
  localparam int          PhaseItems  = 98;
  localparam int          QuietTail   = 150;
  localparam logic [1:0]  KindUnused  = 2'd3;

  // Entries of the stimulus list: a request, a register write, or a pause
  // until every owed response has come back
  typedef enum logic [1:0] {
    StepReq,
    StepCfg,
    StepDrain
  } step_e;

  typedef struct packed {
    step_e         what;
    bfa_pkg::req_t req;
    logic [7:0]    cfg;
    bit            gaps_ok;
  } step_t;

  logic          clk_i       = 1'b0;
  logic          rst_ni      = 1'b0;
  logic          start       = 1'b0;
  logic          busy;
  bfa_pkg::req_t req_i       = '0;
  logic          rsp_valid_o;
  bfa_pkg::rsp_t rsp_o;
  logic          cfg_we_i    = 1'b0;
  logic [7:0]    cfg_wdata_i = '0;

  step_t         todo_q[$];
  bfa_pkg::rsp_t owed_rsp_q[$];
  logic [31:0]   frame_map [bfa_pkg::BitmapWords];
  logic [7:0]    search_words;
  int            bad_cnt   = 0;
  int            in_flight = 0;
  int            gap_left  = 0;
  bit            gap_spent = 1'b0;

  bitmap_frame_allocator u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_o      (rsp_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #(ClkHalfNs) clk_i = ~clk_i;

  // Apply one request to the predicted bitmap and return its response
  function automatic bfa_pkg::rsp_t predict_frame_op(input bfa_pkg::req_t rq);
    bfa_pkg::rsp_t r;
    int            limit;
    bit            found;
    int            w;
    int            b;
    r        = '0;
    r.status = bfa_pkg::StatNoChange;
    case (rq.kind)
      bfa_pkg::KindAlloc: begin
        if (rq.frame_index != 0) begin
          r.result_frame = rq.frame_index;
        end else begin
          limit = (search_words > bfa_pkg::BitmapWords) ? bfa_pkg::BitmapWords : search_words;
          found = 1'b0;
          // First fit: lowest word that is not full, then its lowest clear bit
          for (w = 0; w < limit && !found; w++) begin
            if (frame_map[w] != bfa_pkg::FullWord) begin
              for (b = 0; b < bfa_pkg::WordBits && !found; b++) begin
                if (!frame_map[w][b]) begin
                  found            = 1'b1;
                  frame_map[w][b]  = 1'b1;
                  r.result_frame   = 12'(w * bfa_pkg::WordBits + b);
                  r.status         = bfa_pkg::StatDone;
                  r.entry_present  = 1'b1;
                  r.entry_writable = rq.writable;
                  r.entry_user     = ~rq.kernel_page;
                end
              end
            end
          end
          if (!found) r.status = bfa_pkg::StatNoFrame;
        end
      end
      bfa_pkg::KindFree: begin
        if (rq.frame_index != 0) begin
          frame_map[rq.frame_index / bfa_pkg::WordBits]
                   [rq.frame_index % bfa_pkg::WordBits] = 1'b0;
          r.status = bfa_pkg::StatDone;
        end
      end
      bfa_pkg::KindTest: begin
        r.result_frame = rq.frame_index;
        r.status       = bfa_pkg::StatDone;
        r.frame_used   = frame_map[rq.frame_index / bfa_pkg::WordBits]
                                  [rq.frame_index % bfa_pkg::WordBits];
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic add_request(input logic [1:0] kind, input logic [11:0] frame,
                             input logic kern, input logic wr, input bit gaps_ok);
    step_t s;
    s                 = '0;
    s.what            = StepReq;
    s.req.kind        = kind;
    s.req.frame_index = frame;
    s.req.kernel_page = kern;
    s.req.writable    = wr;
    s.gaps_ok         = gaps_ok;
    todo_q.push_back(s);
  endtask

  // Drain the block, then write the search size
  task automatic add_setting(input logic [7:0] words);
    step_t s;
    s      = '0;
    s.what = StepDrain;
    todo_q.push_back(s);
    s.what = StepCfg;
    s.cfg  = words;
    todo_q.push_back(s);
  endtask

  // Driver: present requests and register writes from the stimulus list
  always @(posedge clk_i) begin : feed_requests
    step_t nxt;
    logic  drv_start;
    logic  drv_we;
    if (rst_ni) begin
      // Count transactions whose response is still owed
      if (start && !busy) in_flight++;
      if (rsp_valid_o) in_flight--;
      drv_start = start && busy;
      drv_we    = 1'b0;
      if (!drv_start) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (todo_q.size() != 0) begin
          nxt = todo_q[0];
          case (nxt.what)
            StepReq: begin
              if (nxt.gaps_ok && !gap_spent && $urandom_range(0, 4) == 0) begin
                gap_left  = $urandom_range(0, 6);
                gap_spent = 1'b1;
              end else begin
                void'(todo_q.pop_front());
                req_i     <= nxt.req;
                drv_start = 1'b1;
                gap_spent = 1'b0;
              end
            end
            StepCfg: begin
              void'(todo_q.pop_front());
              cfg_wdata_i <= nxt.cfg;
              drv_we      = 1'b1;
            end
            default: begin
              // Hold until the allocator has answered everything
              if (in_flight == 0 && !busy) void'(todo_q.pop_front());
            end
          endcase
        end
      end
      start    <= drv_start;
      cfg_we_i <= drv_we;
    end
  end

  // Monitor: predict accepted transactions and check each response strobe
  always @(posedge clk_i) begin : check_responses
    bfa_pkg::rsp_t want;
    int            w;
    if (!rst_ni) begin
      for (w = 0; w < bfa_pkg::BitmapWords; w++) frame_map[w] = '0;
      search_words = 8'd128;
    end else begin
      if (cfg_we_i) search_words = cfg_wdata_i;
      if (start && !busy) owed_rsp_q.push_back(predict_frame_op(req_i));
      if (rsp_valid_o) begin
        if (owed_rsp_q.size() == 0) begin
          bad_cnt++;
          if (bad_cnt <= 10)
            $display("%0t: response with none owed: frame %0d status %0d",
                     $realtime, rsp_o.result_frame, rsp_o.status);
        end else begin
          want = owed_rsp_q.pop_front();
          if (rsp_o.result_frame !== want.result_frame ||
              rsp_o.status !== want.status ||
              rsp_o.frame_used !== want.frame_used ||
              rsp_o.entry_present !== want.entry_present ||
              rsp_o.entry_writable !== want.entry_writable ||
              rsp_o.entry_user !== want.entry_user) begin
            bad_cnt++;
            // Fields: frame/status/used/present-writable-user
            if (bad_cnt <= 10)
              $display("%0t: mismatch: want %0d/%0d/%b/%b%b%b got %0d/%0d/%b/%b%b%b",
                       $realtime,
                       want.result_frame, want.status, want.frame_used,
                       want.entry_present, want.entry_writable, want.entry_user,
                       rsp_o.result_frame, rsp_o.status, rsp_o.frame_used,
                       rsp_o.entry_present, rsp_o.entry_writable, rsp_o.entry_user);
          end
        end
      end
    end
  end

  // Stimulus: directed corners, then random phases over several search sizes
  initial begin : run_stimulus
    int unsigned phase_words [RandPhases];
    int          phase;
    int          n;
    int          pick;
    int          span;
    int          limit;
    int          rand_cnt;
    bit          noisy;
    logic [11:0] f;

    phase_words = '{1, 128, 2, 0, 4, 255, 3, 1, 9, 2, 128};
    phase_words[8] = $urandom_range(5, 254);
    rand_cnt = 0;

    // Grants in order from frame zero, entry bits per kernel and write flags
    add_request(bfa_pkg::KindTest,  12'd0,    1'b0, 1'b0, 1'b1);
    add_request(bfa_pkg::KindAlloc, 12'd0,    1'b0, 1'b1, 1'b1);
    add_request(bfa_pkg::KindAlloc, 12'd0,    1'b1, 1'b0, 1'b1);
    add_request(bfa_pkg::KindAlloc, 12'd0,    1'b0, 1'b0, 1'b1);
    add_request(bfa_pkg::KindAlloc, 12'd0,    1'b1, 1'b1, 1'b1);
    add_request(bfa_pkg::KindTest,  12'd0,    1'b1, 1'b1, 1'b1);
    add_request(bfa_pkg::KindTest,  12'd3,    1'b0, 1'b1, 1'b1);
    add_request(bfa_pkg::KindTest,  12'd4095, 1'b1, 1'b0, 1'b1);
    // Page that already has a frame keeps it
    add_request(bfa_pkg::KindAlloc, 12'd4095, 1'b0, 1'b1, 1'b1);
    add_request(bfa_pkg::KindAlloc, 12'd1,    1'b1, 1'b1, 1'b1);
    // Free of frame zero is a no-op; freed frame is granted again
    add_request(bfa_pkg::KindFree,  12'd0,    1'b1, 1'b1, 1'b1);
    add_request(bfa_pkg::KindFree,  12'd2,    1'b0, 1'b0, 1'b1);
    add_request(bfa_pkg::KindTest,  12'd2,    1'b0, 1'b0, 1'b1);
    add_request(bfa_pkg::KindAlloc, 12'd0,    1'b1, 1'b1, 1'b1);
    add_request(bfa_pkg::KindFree,  12'd4095, 1'b1, 1'b1, 1'b1);
    add_request(bfa_pkg::KindTest,  12'd4095, 1'b0, 1'b0, 1'b1);
    // Unused operation code changes nothing
    add_request(KindUnused,         12'd4095, 1'b1, 1'b1, 1'b1);
    add_request(KindUnused,         12'd0,    1'b0, 1'b0, 1'b1);
    // Empty search range gives no free frame; oversize range is clamped
    add_setting(8'd0);
    add_request(bfa_pkg::KindAlloc, 12'd0,    1'b0, 1'b1, 1'b1);
    add_request(bfa_pkg::KindTest,  12'd1,    1'b0, 1'b0, 1'b1);
    add_setting(8'd255);
    add_request(bfa_pkg::KindAlloc, 12'd0,    1'b0, 1'b1, 1'b1);
    add_request(bfa_pkg::KindTest,  12'd4,    1'b1, 1'b0, 1'b1);

    for (phase = 0; phase < RandPhases; phase++) begin
      add_setting(8'(phase_words[phase]));
      limit = (phase_words[phase] > 128) ? 128 : phase_words[phase];
      span  = (limit == 0) ? 64 : limit * 32;
      for (n = 0; n < PhaseItems; n++) begin
        noisy = (rand_cnt < RandPhases * PhaseItems - QuietTail);
        pick  = $urandom_range(0, 99);
        // Mostly frames inside the searched range, so frees hit granted ones
        f = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, span - 1));
        if (pick < 45)
          add_request(bfa_pkg::KindAlloc, 12'd0, 1'($urandom), 1'($urandom), noisy);
        else if (pick < 53)
          add_request(bfa_pkg::KindAlloc, 12'($urandom), 1'($urandom), 1'($urandom), noisy);
        else if (pick < 73)
          add_request(bfa_pkg::KindFree, f, 1'($urandom), 1'($urandom), noisy);
        else if (pick < 95)
          add_request(bfa_pkg::KindTest, f, 1'($urandom), 1'($urandom), noisy);
        else
          add_request(KindUnused, 12'($urandom), 1'($urandom), 1'($urandom), noisy);
        rand_cnt++;
      end
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for the list to empty and every response to arrive
    do @(negedge clk_i);
    while (todo_q.size() != 0 || start || owed_rsp_q.size() != 0);
    repeat (140) @(negedge clk_i);

    if (bad_cnt == 0 && owed_rsp_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin : watchdog
    #(ClkPeriodNs * 3_000_000);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> bitmap_frame_allocator.f
hdl/bfa_pkg.sv
hdl/bfa_bitmap_mem.sv
hdl/bitmap_frame_allocator.sv
sim/tb_top.sv
